>>> rtl/fpi_pkg.sv
// Shared constants and helpers for the five-point interpolator.
// No dependencies; imported by every module of the block.
package fpi_pkg;

    // Accumulator limb fed to one multiplier in a Horner step.
    localparam int LIMB_W = 32;

    // Quotient bits resolved per divide-by-3 stage.
    localparam int DIV_DIGITS = 8;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

>>> rtl/five_point_interpolator_core.sv
// Top level of the five-point central-difference interpolator.
// Uses fpi_pkg, fpi_diff, fpi_horner_step and fpi_post.
//
// Five equally spaced signed samples (Q.FRAC_BITS) and a signed factor n
// (Q1.FRAC_BITS, zero at the middle sample) go in; the quartic central-
// difference interpolant about the middle sample comes out, floored toward
// minus infinity and exact, with no intermediate rounding. Results outside
// the SAMPLE_WIDTH signed range clamp to the nearest extreme with
// o_overflow set. Factors beyond +-1.0 are evaluated exactly (extrapolation).
// The block is a fully pipelined datapath: one item per clock while the
// output is not stalled. It is built from four difference/coefficient
// stages, four Horner multiply/add step pairs (the sum is evaluated in
// powers of n, each step a row of 32-bit limb multipliers then an adder),
// a range check, the divide-by-3 digit stages (8 quotient bits each) and
// the output register. No state survives between items. A stall on the
// output holds the last stage; bubbles inside the pipe are squeezed out
// first, and o_stall rises only when every stage holds an item.
module five_point_interpolator_core #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int FRAC_BITS    = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [FRAC_BITS+1:0]    i_factor,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_a,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_b,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_c,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_d,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_e,
    // result channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_interpolated,
    output logic                           o_overflow
);
    import fpi_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int FW = F + 2;

    // coefficient widths (bounded by the sum of |taps| times the sample range)
    localparam int C1W = SW + 6;   // 12(B+C) - 2(H+J)
    localparam int C2W = SW + 7;   // 12F - K
    localparam int C3W = SW + 4;   // 2(H+J)
    localparam int C4W = SW + 4;   // K
    localparam int YW  = SW + 5;   // 24*y3

    // Horner: S = (((c4*n + c3<<F)*n + c2<<2F)*n + c1<<3F)*n + 24*y3<<4F
    localparam int W3 = imax(C4W + FW, C3W + F) + 1;
    localparam int W2 = imax(W3 + FW, C2W + 2 * F) + 1;
    localparam int W1 = imax(W2 + FW, C1W + 3 * F) + 1;
    localparam int WS = imax(W1 + FW, YW + 4 * F) + 1;

    // sideband: remaining terms above the factor
    localparam int XW1 = YW + C1W + C2W + FW;
    localparam int XW2 = YW + C1W + FW;
    localparam int XW3 = YW + FW;
    localparam int XW4 = FW;

    logic                  d_valid, d_stall;
    logic signed [C1W-1:0] d_c1;
    logic signed [C2W-1:0] d_c2;
    logic signed [C3W-1:0] d_c3;
    logic signed [C4W-1:0] d_c4;
    logic signed [YW-1:0]  d_y24;
    logic signed [FW-1:0]  d_factor;

    logic                  h1_valid, h1_stall;
    logic                  h2_valid, h2_stall;
    logic                  h3_valid, h3_stall;
    logic                  h4_valid, h4_stall;
    logic signed [W3-1:0]  h1_acc;
    logic signed [W2-1:0]  h2_acc;
    logic signed [W1-1:0]  h3_acc;
    logic signed [WS-1:0]  h4_acc;
    logic [XW1-1:0]        side1_in, side1_out;
    logic [XW2-1:0]        side2_in, side2_out;
    logic [XW3-1:0]        side3_in, side3_out;
    logic [XW4-1:0]        side4_in;

    fpi_diff #(
        .SW (SW),
        .FW (FW)
    ) u_diff (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (d_valid),
        .i_stall  (d_stall),
        .i_factor (i_factor),
        .i_y1     (i_sample_a),
        .i_y2     (i_sample_b),
        .i_y3     (i_sample_c),
        .i_y4     (i_sample_d),
        .i_y5     (i_sample_e),
        .o_c1     (d_c1),
        .o_c2     (d_c2),
        .o_c3     (d_c3),
        .o_c4     (d_c4),
        .o_y24    (d_y24),
        .o_factor (d_factor)
    );

    // step 1: c4*n + c3<<F
    assign side1_in = {d_y24, d_c1, d_c2, d_factor};

    fpi_horner_step #(
        .AW (C4W), .TW (C3W), .SH (F), .OW (W3), .XW (XW1), .FW (FW)
    ) u_step1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d_valid),
        .o_stall (d_stall),
        .o_valid (h1_valid),
        .i_stall (h1_stall),
        .i_acc   (d_c4),
        .i_term  (d_c3),
        .i_side  (side1_in),
        .o_acc   (h1_acc),
        .o_side  (side1_out)
    );

    // step 2: + c2<<2F
    assign side2_in = {side1_out[XW1-1:FW+C2W], side1_out[FW-1:0]};

    fpi_horner_step #(
        .AW (W3), .TW (C2W), .SH (2 * F), .OW (W2), .XW (XW2), .FW (FW)
    ) u_step2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (h1_valid),
        .o_stall (h1_stall),
        .o_valid (h2_valid),
        .i_stall (h2_stall),
        .i_acc   (h1_acc),
        .i_term  ($signed(side1_out[FW +: C2W])),
        .i_side  (side2_in),
        .o_acc   (h2_acc),
        .o_side  (side2_out)
    );

    // step 3: + c1<<3F
    assign side3_in = {side2_out[XW2-1:FW+C1W], side2_out[FW-1:0]};

    fpi_horner_step #(
        .AW (W2), .TW (C1W), .SH (3 * F), .OW (W1), .XW (XW3), .FW (FW)
    ) u_step3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (h2_valid),
        .o_stall (h2_stall),
        .o_valid (h3_valid),
        .i_stall (h3_stall),
        .i_acc   (h2_acc),
        .i_term  ($signed(side2_out[FW +: C1W])),
        .i_side  (side3_in),
        .o_acc   (h3_acc),
        .o_side  (side3_out)
    );

    // step 4: + 24*y3<<4F; factor is no longer needed afterwards
    assign side4_in = side3_out[FW-1:0];

    fpi_horner_step #(
        .AW (W1), .TW (YW), .SH (4 * F), .OW (WS), .XW (XW4), .FW (FW)
    ) u_step4 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (h3_valid),
        .o_stall (h3_stall),
        .o_valid (h4_valid),
        .i_stall (h4_stall),
        .i_acc   (h3_acc),
        .i_term  ($signed(side3_out[FW +: YW])),
        .i_side  (side4_in),
        .o_acc   (h4_acc),
        .o_side  ()
    );

    fpi_post #(
        .WS (WS),
        .SW (SW),
        .F  (F)
    ) u_post (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (h4_valid),
        .o_stall        (h4_stall),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .i_sum          (h4_acc),
        .o_interpolated (o_interpolated),
        .o_overflow     (o_overflow)
    );

endmodule

>>> rtl/fpi_diff.sv
// Difference table and polynomial coefficients, four register stages.
// Depends on fpi_pkg.
module fpi_diff #(
    parameter int SW = 32,
    parameter int FW = 18
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    output logic                 o_valid,
    input  logic                 i_stall,
    input  logic signed [FW-1:0] i_factor,
    input  logic signed [SW-1:0] i_y1,
    input  logic signed [SW-1:0] i_y2,
    input  logic signed [SW-1:0] i_y3,
    input  logic signed [SW-1:0] i_y4,
    input  logic signed [SW-1:0] i_y5,
    output logic signed [SW+5:0] o_c1,
    output logic signed [SW+6:0] o_c2,
    output logic signed [SW+3:0] o_c3,
    output logic signed [SW+3:0] o_c4,
    output logic signed [SW+4:0] o_y24,
    output logic signed [FW-1:0] o_factor
);
    import fpi_pkg::*;

    localparam int W1 = SW + 1;
    localparam int W2 = SW + 2;
    localparam int W3 = SW + 3;
    localparam int NSTG = 4;

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] stall;

    // stage 1: first differences
    logic signed [W1-1:0] r1_a, r1_b, r1_c, r1_d;
    logic signed [SW-1:0] r1_y3;
    logic signed [FW-1:0] r1_n;
    // stage 2: second differences, B+C
    logic signed [W2-1:0] r2_e, r2_f, r2_g, r2_bc;
    logic signed [SW-1:0] r2_y3;
    logic signed [FW-1:0] r2_n;
    // stage 3: third differences
    logic signed [W3-1:0] r3_h, r3_j;
    logic signed [W2-1:0] r3_f, r3_bc;
    logic signed [SW-1:0] r3_y3;
    logic signed [FW-1:0] r3_n;
    // stage 4: coefficients
    logic signed [SW+5:0] r4_c1, n_c1;
    logic signed [SW+6:0] r4_c2, n_c2;
    logic signed [SW+3:0] r4_c3, n_c3;
    logic signed [SW+3:0] r4_c4, n_c4;
    logic signed [SW+4:0] r4_y24, n_y24;
    logic signed [FW-1:0] r4_n;

    always_comb begin
        stall[NSTG-1] = r_v[NSTG-1] && i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            stall[k] = r_v[k] && stall[k+1];
        end
    end

    assign o_stall = stall[0];
    assign o_valid = r_v[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (!stall[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (!stall[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // 12x = 8x + 4x; all sums wrap harmlessly since the finals fit
    always_comb begin
        n_c1  = (($bits(n_c1))'(r3_bc) <<< 3) + (($bits(n_c1))'(r3_bc) <<< 2)
              - (($bits(n_c1))'(r3_h) <<< 1) - (($bits(n_c1))'(r3_j) <<< 1);
        n_c2  = (($bits(n_c2))'(r3_f) <<< 3) + (($bits(n_c2))'(r3_f) <<< 2)
              - ($bits(n_c2))'(r3_j) + ($bits(n_c2))'(r3_h);
        n_c3  = (($bits(n_c3))'(r3_h) <<< 1) + (($bits(n_c3))'(r3_j) <<< 1);
        n_c4  = ($bits(n_c4))'(r3_j) - ($bits(n_c4))'(r3_h);
        n_y24 = (($bits(n_y24))'(r3_y3) <<< 4) + (($bits(n_y24))'(r3_y3) <<< 3);
    end

    always_ff @(posedge i_clk) begin
        if (!stall[0]) begin
            r1_a  <= W1'(i_y2) - W1'(i_y1);
            r1_b  <= W1'(i_y3) - W1'(i_y2);
            r1_c  <= W1'(i_y4) - W1'(i_y3);
            r1_d  <= W1'(i_y5) - W1'(i_y4);
            r1_y3 <= i_y3;
            r1_n  <= i_factor;
        end
        if (!stall[1]) begin
            r2_e  <= W2'(r1_b) - W2'(r1_a);
            r2_f  <= W2'(r1_c) - W2'(r1_b);
            r2_g  <= W2'(r1_d) - W2'(r1_c);
            r2_bc <= W2'(r1_b) + W2'(r1_c);
            r2_y3 <= r1_y3;
            r2_n  <= r1_n;
        end
        if (!stall[2]) begin
            r3_h  <= W3'(r2_f) - W3'(r2_e);
            r3_j  <= W3'(r2_g) - W3'(r2_f);
            r3_f  <= r2_f;
            r3_bc <= r2_bc;
            r3_y3 <= r2_y3;
            r3_n  <= r2_n;
        end
        if (!stall[3]) begin
            r4_c1  <= n_c1;
            r4_c2  <= n_c2;
            r4_c3  <= n_c3;
            r4_c4  <= n_c4;
            r4_y24 <= n_y24;
            r4_n   <= r3_n;
        end
    end

    assign o_c1     = r4_c1;
    assign o_c2     = r4_c2;
    assign o_c3     = r4_c3;
    assign o_c4     = r4_c4;
    assign o_y24    = r4_y24;
    assign o_factor = r4_n;

endmodule

>>> rtl/fpi_horner_step.sv
// One Horner step: acc*factor + (term << SH), limb partial products then sum.
// Depends on fpi_pkg (LIMB_W). Factor rides in the low FW bits of the sideband.
module fpi_horner_step #(
    parameter int AW = 36,
    parameter int TW = 36,
    parameter int SH = 16,
    parameter int OW = 55,
    parameter int XW = 18,
    parameter int FW = 18
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    output logic                 o_valid,
    input  logic                 i_stall,
    input  logic signed [AW-1:0] i_acc,
    input  logic signed [TW-1:0] i_term,
    input  logic        [XW-1:0] i_side,
    output logic signed [OW-1:0] o_acc,
    output logic        [XW-1:0] o_side
);
    import fpi_pkg::*;

    localparam int NL = (AW + LIMB_W - 1) / LIMB_W;
    localparam int EW = NL * LIMB_W;
    localparam int PW = LIMB_W + 1 + FW;

    logic [1:0] r_v;
    logic [1:0] stall;

    logic signed [EW-1:0] acc_ext;
    logic signed [PW-1:0] n_pp [NL];
    logic signed [PW-1:0] r_pp [NL];
    logic signed [TW-1:0] r_term;
    logic        [XW-1:0] r_side_a;
    logic signed [OW-1:0] n_acc;
    logic signed [OW-1:0] r_acc;
    logic        [XW-1:0] r_side_b;

    assign stall[1] = r_v[1] && i_stall;
    assign stall[0] = r_v[0] && stall[1];
    assign o_stall  = stall[0];
    assign o_valid  = r_v[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (!stall[0]) r_v[0] <= i_valid;
            if (!stall[1]) r_v[1] <= r_v[0];
        end
    end

    // lower limbs unsigned, top limb carries the sign
    assign acc_ext = EW'(i_acc);

    always_comb begin
        logic [LIMB_W-1:0] limb;
        logic              ext;
        for (int i = 0; i < NL; i++) begin
            limb    = acc_ext[i*LIMB_W +: LIMB_W];
            ext     = (i == NL - 1) ? limb[LIMB_W-1] : 1'b0;
            n_pp[i] = $signed({ext, limb}) * $signed(i_side[FW-1:0]);
        end
    end

    always_comb begin
        n_acc = OW'(r_term) <<< SH;
        for (int i = 0; i < NL; i++) begin
            n_acc = n_acc + (OW'(r_pp[i]) <<< (i * LIMB_W));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall[0]) begin
            for (int i = 0; i < NL; i++) begin
                r_pp[i] <= n_pp[i];
            end
            r_term   <= i_term;
            r_side_a <= i_side;
        end
        if (!stall[1]) begin
            r_acc    <= n_acc;
            r_side_b <= r_side_a;
        end
    end

    assign o_acc  = r_acc;
    assign o_side = r_side_b;

endmodule

>>> rtl/fpi_post.sv
// Final scaling: floor(S / 2^(4F)) then floor(/24) with saturation.
// Range check stage, digit-serial divide-by-3 stages, output register. Uses fpi_pkg.
module fpi_post #(
    parameter int WS = 112,
    parameter int SW = 32,
    parameter int F  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    output logic                 o_valid,
    input  logic                 i_stall,
    input  logic signed [WS-1:0] i_sum,
    output logic signed [SW-1:0] o_interpolated,
    output logic                 o_overflow
);
    import fpi_pkg::*;

    localparam int TW = WS - 4 * F;
    localparam int QW = SW + 2;
    localparam int NS = (QW + DIV_DIGITS - 1) / DIV_DIGITS;
    localparam int PS = NS + 2;

    // result fits iff -24*2^(SW-1) <= T < 24*2^(SW-1)
    localparam logic signed [TW-1:0] LIM_HI =
        {{(TW - SW - 4){1'b0}}, 5'd24, {(SW - 1){1'b0}}};
    localparam logic signed [TW-1:0] LIM_LO = -LIM_HI;
    // bias so floor(T/8) becomes non-negative before the divide by 3
    localparam logic [QW-1:0] OFFSET = {1'b0, 2'b11, {(SW - 1){1'b0}}};
    localparam logic [SW-1:0] MAXV = {1'b0, {(SW - 1){1'b1}}};
    localparam logic [SW-1:0] MINV = {1'b1, {(SW - 1){1'b0}}};

    logic [PS-1:0] r_v;
    logic [PS-1:0] stall;

    logic signed [TW-1:0] t_val;
    logic [QW-1:0] n_num [NS+1];
    logic [1:0]    n_rem [NS+1];
    logic [QW-1:0] r_num [NS+1];
    logic [1:0]    r_rem [NS+1];
    logic          r_pos [NS+1];
    logic          r_neg [NS+1];
    logic [SW-1:0] n_res;
    logic          n_ovf;
    logic [SW-1:0] r_res;
    logic          r_ovf;

    always_comb begin
        stall[PS-1] = r_v[PS-1] && i_stall;
        for (int k = PS - 2; k >= 0; k--) begin
            stall[k] = r_v[k] && stall[k+1];
        end
    end

    assign o_stall = stall[0];
    assign o_valid = r_v[PS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (!stall[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < PS; k++) begin
                if (!stall[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign t_val = i_sum[WS-1:4*F];

    // restoring division by 3, MSB first, quotient bits replace dividend bits
    always_comb begin
        logic [QW-1:0] num;
        logic [1:0]    rem;
        logic [2:0]    tr;
        int            pos;
        n_num[0] = t_val[QW+2:3] + OFFSET;
        n_rem[0] = '0;
        for (int k = 1; k <= NS; k++) begin
            num = r_num[k-1];
            rem = r_rem[k-1];
            for (int j = 0; j < DIV_DIGITS; j++) begin
                pos = (k - 1) * DIV_DIGITS + j;
                if (pos < QW) begin
                    tr = {rem, num[QW-1-pos]};
                    if (tr >= 3'd3) begin
                        num[QW-1-pos] = 1'b1;
                        rem           = 2'(tr - 3'd3);
                    end else begin
                        num[QW-1-pos] = 1'b0;
                        rem           = tr[1:0];
                    end
                end
            end
            n_num[k] = num;
            n_rem[k] = rem;
        end
    end

    // quotient carries a +2^(SW-1) bias: flip the top bit to remove it
    always_comb begin
        n_res = {~r_num[NS][SW-1], r_num[NS][SW-2:0]};
        n_ovf = 1'b0;
        if (r_pos[NS]) begin
            n_res = MAXV;
            n_ovf = 1'b1;
        end else if (r_neg[NS]) begin
            n_res = MINV;
            n_ovf = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall[0]) begin
            r_num[0] <= n_num[0];
            r_rem[0] <= n_rem[0];
            r_pos[0] <= (t_val >= LIM_HI);
            r_neg[0] <= (t_val < LIM_LO);
        end
        for (int k = 1; k <= NS; k++) begin
            if (!stall[k]) begin
                r_num[k] <= n_num[k];
                r_rem[k] <= n_rem[k];
                r_pos[k] <= r_pos[k-1];
                r_neg[k] <= r_neg[k-1];
            end
        end
        if (!stall[PS-1]) begin
            r_res <= n_res;
            r_ovf <= n_ovf;
        end
    end

    assign o_interpolated = r_res;
    assign o_overflow     = r_ovf;

`ifndef SYNTH
    a_sat_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] |-> !(r_pos[0] && r_neg[0]))
        else $error("both saturation directions flagged");

    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NS] && !r_pos[NS] && !r_neg[NS]) |-> (r_num[NS][QW-1:QW-2] == 2'b00))
        else $error("in-range quotient exceeds result width");

    a_ovf_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (o_interpolated == MAXV || o_interpolated == MINV))
        else $error("overflow without saturated value");

    a_stall_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("upstream stall without a held result");
`endif

endmodule

>>> verif/tb_five_point_interpolator_core.sv
// Testbench for five_point_interpolator_core: directed corner tables, then random tables,
// with bursty input and patterned output stall, checked by an exact wide-integer predictor.
// Depends only on the RTL of the block (fpi_pkg and the core hierarchy).
module tb_five_point_interpolator_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW = 32;                 // sample width
    localparam int FB = 16;                 // fraction bits
    localparam int FW = FB + 2;             // factor width
    localparam int WIDE = 192;              // headroom for S; worst term is ~2^104

    localparam int ONE  = 1 << FB;          // factor 1.0
    localparam int FMAX = (1 << (FB + 1)) - 1;
    localparam int FMIN = -(1 << (FB + 1));

    localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

    localparam int RANDOM_ITEMS  = 1400;
    localparam int DRAIN_EVERY   = 350;     // random items between forced drains
    localparam int FLUSH_CYCLES  = 40;      // extra cycles waited after the final drain
    localparam int IDLE_LIMIT    = 2000;    // cycles with no item moving on either side

    typedef logic signed [WIDE-1:0] t_wide;

    typedef struct packed {
        logic signed [FW-1:0] factor;
        logic signed [SW-1:0] s_a;
        logic signed [SW-1:0] s_b;
        logic signed [SW-1:0] s_c;
        logic signed [SW-1:0] s_d;
        logic signed [SW-1:0] s_e;
    } t_request;

    typedef struct packed {
        logic signed [SW-1:0] value;
        logic                 ovf;
    } t_outcome;

    typedef enum logic [1:0] {RX_FREE, RX_SPOTTY, RX_BURSTY} t_rx_mode;

    // Holds the interpolants still owed by the block, oldest first.
    class interp_ledger;
        t_outcome    pending_values[$];
        int unsigned faults;

        // Exact quartic central-difference interpolant, floored, then clamped.
        function t_outcome quartic_interpolate(t_request r);
            t_wide    y1, y2, y3, y4, y5, n;
            t_wide    da, db, dc, dd, ea, eb, ec, t1, t2, q4, c1, c2, c3;
            t_wide    total, q;
            t_outcome o;
            n  = $signed(r.factor);
            y1 = $signed(r.s_a);
            y2 = $signed(r.s_b);
            y3 = $signed(r.s_c);
            y4 = $signed(r.s_d);
            y5 = $signed(r.s_e);
            da = y2 - y1;
            db = y3 - y2;
            dc = y4 - y3;
            dd = y5 - y4;
            ea = db - da;
            eb = dc - db;
            ec = dd - dc;
            t1 = eb - ea;
            t2 = ec - eb;
            q4 = t2 - t1;
            c1 = 12 * (db + dc) - 2 * (t1 + t2);
            c2 = 12 * eb - q4;
            c3 = 2 * (t1 + t2);
            total = ((24 * y3) <<< (4 * FB))
                  + ((c1 * n) <<< (3 * FB))
                  + ((c2 * n * n) <<< (2 * FB))
                  + ((c3 * n * n * n) <<< FB)
                  + (q4 * n * n * n * n);
            // floor by 2^(4f) via arithmetic shift, then floor by 24
            q = total >>> (4 * FB);
            if (q < 0)
                q = -((-q + 23) / 24);
            else
                q = q / 24;
            if (q > t_wide'(SAMPLE_MAX)) begin
                o.value = SAMPLE_MAX;
                o.ovf   = 1'b1;
            end else if (q < t_wide'(SAMPLE_MIN)) begin
                o.value = SAMPLE_MIN;
                o.ovf   = 1'b1;
            end else begin
                o.value = q[SW-1:0];
                o.ovf   = 1'b0;
            end
            return o;
        endfunction

        function void note_request(t_request r);
            pending_values.push_back(quartic_interpolate(r));
        endfunction

        function void check_result(logic signed [SW-1:0] value, logic ovf);
            t_outcome want;
            if (pending_values.size() == 0) begin
                $display("%0t: unexpected item, interpolated %0d overflow %0b",
                         $time, value, ovf);
                faults++;
                return;
            end
            want = pending_values.pop_front();
            if (value !== want.value) begin
                $display("%0t: interpolated expected %0d actual %0d",
                         $time, want.value, value);
                faults++;
            end
            if (ovf !== want.ovf) begin
                $display("%0t: overflow expected %0b actual %0b", $time, want.ovf, ovf);
                faults++;
            end
        endfunction
    endclass

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_valid    = 1'b0;
    logic                 i_stall    = 1'b0;
    logic signed [FW-1:0] i_factor   = '0;
    logic signed [SW-1:0] i_sample_a = '0;
    logic signed [SW-1:0] i_sample_b = '0;
    logic signed [SW-1:0] i_sample_c = '0;
    logic signed [SW-1:0] i_sample_d = '0;
    logic signed [SW-1:0] i_sample_e = '0;
    logic                 o_stall;
    logic                 o_valid;
    logic signed [SW-1:0] o_interpolated;
    logic                 o_overflow;

    interp_ledger ledger = new;
    int           idle_cycles = 0;

    five_point_interpolator_core #(
        .SAMPLE_WIDTH (SW),
        .FRAC_BITS    (FB)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_factor       (i_factor),
        .i_sample_a     (i_sample_a),
        .i_sample_b     (i_sample_b),
        .i_sample_c     (i_sample_c),
        .i_sample_d     (i_sample_d),
        .i_sample_e     (i_sample_e),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_interpolated (o_interpolated),
        .o_overflow     (o_overflow)
    );

    always #10 i_clk = ~i_clk;

    // Monitor: both handshakes are judged on pre-edge values.
    always @(posedge i_clk) begin
        logic took_in, took_out;
        took_in  = i_rst_n && i_valid && !o_stall;
        took_out = i_rst_n && o_valid && !i_stall;
        if (took_in)
            ledger.note_request(t_request'({i_factor, i_sample_a, i_sample_b,
                                            i_sample_c, i_sample_d, i_sample_e}));
        if (took_out)
            ledger.check_result(o_interpolated, o_overflow);
        idle_cycles <= (took_in || took_out) ? 0 : idle_cycles + 1;
    end

    // Result-side stall: free-running, spotty, or long on/off runs, re-picked
    // whenever the low byte of rx_cycle is zero, so stalls land on every pipe phase.
    t_rx_mode rx_mode  = RX_FREE;
    int       rx_cycle = 0;
    int       rx_run   = 0;

    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle[7:0] == 8'd0)
            rx_mode <= t_rx_mode'($urandom_range(2));
        case (rx_mode)
            RX_FREE: begin
                i_stall <= 1'b0;
            end
            RX_SPOTTY: begin
                i_stall <= ($urandom_range(3) == 0);
            end
            default: begin
                if (rx_run != 0) begin
                    rx_run <= rx_run - 1;
                end else begin
                    i_stall <= !i_stall;
                    rx_run  <= i_stall ? $urandom_range(6) : $urandom_range(30);
                end
            end
        endcase
    end

    initial begin : watchdog
        wait (idle_cycles >= IDLE_LIMIT);
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic t_request make_request(int f, logic signed [SW-1:0] a,
                                              logic signed [SW-1:0] b,
                                              logic signed [SW-1:0] c,
                                              logic signed [SW-1:0] d,
                                              logic signed [SW-1:0] e);
        t_request r;
        r.factor = FW'(f);
        r.s_a = a;
        r.s_b = b;
        r.s_c = c;
        r.s_d = d;
        r.s_e = e;
        return r;
    endfunction

    // Mostly smooth tables with factor in +-1.0; the rest is full-range noise,
    // rail values and alternating tables, plus factors beyond +-1.0.
    function automatic t_request random_request();
        t_request             r;
        logic signed [SW-1:0] base, step, bend, amp, noise;
        logic signed [SW-1:0] pick [5];
        int                   style, shape, k;
        style = $urandom_range(9);
        base  = $urandom;
        step  = $signed($urandom) >>> $urandom_range(31);
        bend  = $signed($urandom) >>> $urandom_range(31, 10);
        amp   = $signed($urandom) >>> $urandom_range(31);
        for (k = 0; k < 5; k++) begin
            noise = $signed($urandom) >>> $urandom_range(31, 18);
            if (style < 6)
                pick[k] = base + (k - 2) * step + (k - 2) * (k - 2) * bend + noise;
            else if (style < 8)
                pick[k] = $urandom;
            else if (style == 8)
                case ($urandom_range(5))
                    0:       pick[k] = SAMPLE_MIN;
                    1:       pick[k] = SAMPLE_MAX;
                    2:       pick[k] = '0;
                    3:       pick[k] = -1;
                    4:       pick[k] = 1;
                    default: pick[k] = $urandom;
                endcase
            else
                pick[k] = base + ((k % 2 == 1) ? -amp : amp);
        end
        shape = $urandom_range(19);
        if (shape < 15)
            r.factor = FW'(int'($urandom_range(2 * ONE)) - ONE);
        else if (shape < 18)
            r.factor = FW'($urandom);
        else
            case ($urandom_range(4))
                0:       r.factor = FW'(FMIN);
                1:       r.factor = FW'(FMAX);
                2:       r.factor = FW'(-ONE);
                3:       r.factor = FW'(ONE);
                default: r.factor = '0;
            endcase
        r.s_a = pick[0];
        r.s_b = pick[1];
        r.s_c = pick[2];
        r.s_d = pick[3];
        r.s_e = pick[4];
        return r;
    endfunction

    // Present one item and hold it until the block takes it.
    task automatic send_item(input t_request r);
        i_valid    <= 1'b1;
        i_factor   <= r.factor;
        i_sample_a <= r.s_a;
        i_sample_b <= r.s_b;
        i_sample_c <= r.s_c;
        i_sample_d <= r.s_d;
        i_sample_e <= r.s_e;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0) begin
            i_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Stop sending until every owed result has come out.
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (ledger.pending_values.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int sent, burst, next_drain;
        sent       = 0;
        next_drain = DRAIN_EVERY;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero, exact taps at n = -1/0/+1, rails, factor extremes,
        // alternating tables for both overflow directions, flooring of negatives.
        send_item(make_request(0, 0, 0, 0, 0, 0));
        send_item(make_request(0, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN));
        send_item(make_request(0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX));
        send_item(make_request(ONE, 100, 200, 300, 400, 500));
        send_item(make_request(-ONE, 100, 200, 300, 400, 500));
        send_item(make_request(ONE / 2, 100, 200, 300, 400, 500));
        send_item(make_request(FMAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
                               SAMPLE_MAX));
        send_item(make_request(FMIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN,
                               SAMPLE_MIN));
        send_item(make_request(FMAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN,
                               SAMPLE_MAX));
        send_item(make_request(FMIN, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX,
                               SAMPLE_MIN));
        send_item(make_request(FMAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX,
                               SAMPLE_MIN));
        send_item(make_request(ONE, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN,
                               SAMPLE_MAX));
        send_item(make_request(-ONE, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX,
                               SAMPLE_MIN));
        send_item(make_request(ONE / 2, 0, 0, -1, 0, 0));
        send_item(make_request(1, 0, 0, -1, 0, 0));
        send_item(make_request(-1, 7, -3, 5, 11, -2));
        send_item(make_request(ONE / 3, 4 << FB, 1 << FB, 0, 1 << FB, 4 << FB));
        send_item(make_request(-ONE / 4, 16 << FB, 1 << FB, 0, 1 << FB, 16 << FB));
        send_item(make_request(FMAX, -1, -1, -1, -1, -1));
        send_item(make_request(FMIN, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F,
                               32'hF0F0_F0F0, 32'h3333_3333));
        wait_for_drain();

        // Random: bursts of random length, gaps of random length, some with none.
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(40, 1);
            repeat (burst) begin
                send_item(random_request());
                sent++;
            end
            if (sent >= next_drain) begin
                wait_for_drain();
                next_drain += DRAIN_EVERY;
            end else if ($urandom_range(3) != 0) begin
                idle_gap($urandom_range(25, 1));
            end
        end

        wait_for_drain();
        repeat (FLUSH_CYCLES) @(posedge i_clk);

        if (ledger.pending_values.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, ledger.pending_values.size());
            ledger.faults++;
        end
        if (ledger.faults == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/fpi_pkg.sv
rtl/fpi_diff.sv
rtl/fpi_horner_step.sv
rtl/fpi_post.sv
rtl/five_point_interpolator_core.sv
verif/tb_five_point_interpolator_core.sv
